### sv/bmf_pkg.sv
// ----------------------------------------------------------------------------
// bmf_pkg: shared types and constants of the box mean image filter
// Holds field widths, default sizes, action and register codes and the
// controller state type.
// ----------------------------------------------------------------------------
package bmf_pkg;

   // Default sizes of the frame store and of the window
   localparam int DEF_MAX_WIDTH  = 512;
   localparam int DEF_MAX_HEIGHT = 512;
   localparam int DEF_MAX_RADIUS = 15;

   // Field widths
   localparam int COORD_W = 9;
   localparam int CHAN_W  = 8;
   localparam int PIX_W   = 4 * CHAN_W;
   localparam int RAD_W   = 4;
   localparam int SIZE_W  = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   // Item actions
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLED      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd3;

   // Controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_CENTRE,
      S_SWEEP,
      S_DRAIN,
      S_DIV,
      S_FINISH
   } bmf_state_type;

endpackage

### sv/bmf_if.sv
// ----------------------------------------------------------------------------
// bmf interfaces: valid/ready channels of the box mean image filter
// Query/load channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface bmf_req_if;
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic [bmf_pkg::COORD_W-1:0]   col;
   logic [bmf_pkg::COORD_W-1:0]   row;
   logic [bmf_pkg::CHAN_W-1:0]    blue_in;
   logic [bmf_pkg::CHAN_W-1:0]    green_in;
   logic [bmf_pkg::CHAN_W-1:0]    red_in;
   logic [bmf_pkg::CHAN_W-1:0]    alpha_in;

   modport source (output valid, action, col, row, blue_in, green_in, red_in, alpha_in,
                   input ready);
   modport sink   (input valid, action, col, row, blue_in, green_in, red_in, alpha_in,
                   output ready);
endinterface

interface bmf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bmf_pkg::CHAN_W-1:0]    blue_out;
   logic [bmf_pkg::CHAN_W-1:0]    green_out;
   logic [bmf_pkg::CHAN_W-1:0]    red_out;
   logic [bmf_pkg::CHAN_W-1:0]    alpha_out;
   logic                          applied;

   modport source (output valid, blue_out, green_out, red_out, alpha_out, applied,
                   input ready);
   modport sink   (input valid, blue_out, green_out, red_out, alpha_out, applied,
                   output ready);
endinterface

interface bmf_csr_if;
   logic                             valid;
   logic                             ready;
   logic [bmf_pkg::CSR_IDX_W-1:0]    index;
   logic [bmf_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### sv/box_mean_image_filter.sv
// ----------------------------------------------------------------------------
// box_mean_image_filter: box blur over a stored BGRA frame
// Frame store in one synchronous memory, window sweep, bit-serial mean.
// ----------------------------------------------------------------------------
// A load item writes one BGRA pixel into the frame store and gives no
// result; loads or queries outside the frame in use are dropped. A
// query item reads the centre pixel, then sweeps the clipped square window one
// memory read per cycle, then divides the three channel sums by the pixel count
// one quotient bit per cycle. A query passes through the states centre read,
// sweep, drain, divide and finish, and the next item is taken only once the
// block is back in idle. The sweep reads N pixels through the single read port
// of the frame store, where N is the clipped window size ((2*radius+1)^2 at
// most, 961 at radius 15). With the filter disabled a query passes through
// centre read, drain and finish only, and returns the stored pixel with
// applied low. The finished result sits in an output register, so the next
// item is taken while it waits; a query finishing while the previous result is
// still held stalls in its finish cycle until that result is taken. Register
// writes are accepted at any time but must only be issued while the block is
// idle. Pixels must be loaded before any query reads them.
// ----------------------------------------------------------------------------
module box_mean_image_filter #(
   parameter int MAX_WIDTH  = bmf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bmf_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_RADIUS = bmf_pkg::DEF_MAX_RADIUS
) (
   input  logic     clock,
   input  logic     reset,
   bmf_req_if.sink  req_bus,
   bmf_rsp_if.source rsp_bus,
   bmf_csr_if.sink  csr_bus
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WIN   = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
   localparam int SUMW  = $clog2(WIN * 255 + 1);
   localparam int CNTW  = $clog2(WIN + 1);
   localparam int DW    = CNTW + bmf_pkg::CHAN_W - 1;
   localparam int XW    = (SUMW > DW) ? SUMW : DW;
   localparam int SW    = bmf_pkg::SIZE_W;
   localparam int CHW   = bmf_pkg::CHAN_W;

   // Configuration registers
   logic                       enabled_ff;
   logic [bmf_pkg::RAD_W-1:0]  radius_ff;
   logic [SW-1:0]              fwidth_ff;
   logic [SW-1:0]              fheight_ff;

   // Controller and sweep state
   bmf_pkg::bmf_state_type state_ff, state_in;
   logic [AW-1:0]      cen_addr_ff;
   logic [SW-1:0]      x_ff, y_ff, left_ff, right_ff, bottom_ff;
   logic [CNTW-1:0]    cnt_ff;
   logic               acc_en_ff, cen_en_ff, pass_ff;
   logic [2:0]         step_ff;
   logic [SUMW-1:0]    sum_ff [3];
   logic [DW-1:0]      div_ff;
   logic [CHW-1:0]     q_ff [3];
   logic [bmf_pkg::PIX_W-1:0] centre_ff;

   // Frame store
   logic [bmf_pkg::PIX_W-1:0] mem [DEPTH];
   logic [bmf_pkg::PIX_W-1:0] mem_q_ff;
   logic               mem_we, mem_re;
   logic [AW-1:0]      wr_addr, rd_addr, req_addr, sweep_addr;

   // Output register
   logic               rsp_valid_ff;
   logic [CHW-1:0]     rsp_b_ff, rsp_g_ff, rsp_r_ff, rsp_a_ff;
   logic               rsp_applied_ff;

   // Frame size and radius, saturated
   logic [SW-1:0]              w_sat, h_sat;
   logic [bmf_pkg::RAD_W-1:0]  rad;
   logic [SW-1:0]              col_x, row_y, col_hi, row_hi;
   logic [SW-1:0]              left_c, right_c, top_c, bottom_c;
   logic                       in_frame, req_fire, out_free;

   // Divider step
   logic [SUMW-1:0]    rem_next [3];
   logic               qbit [3];

   always_comb begin
      if (fwidth_ff == '0) begin
         w_sat = SW'(1);
      end else if (32'(fwidth_ff) > 32'(MAX_WIDTH)) begin
         w_sat = SW'(MAX_WIDTH);
      end else begin
         w_sat = fwidth_ff;
      end
      if (fheight_ff == '0) begin
         h_sat = SW'(1);
      end else if (32'(fheight_ff) > 32'(MAX_HEIGHT)) begin
         h_sat = SW'(MAX_HEIGHT);
      end else begin
         h_sat = fheight_ff;
      end
      if (32'(radius_ff) > 32'(MAX_RADIUS)) begin
         rad = bmf_pkg::RAD_W'(MAX_RADIUS);
      end else begin
         rad = radius_ff;
      end
   end

   // Clip the window to the frame edges
   always_comb begin
      col_x  = SW'(req_bus.col);
      row_y  = SW'(req_bus.row);
      col_hi = col_x + SW'(rad);
      row_hi = row_y + SW'(rad);
      left_c   = (col_x >= SW'(rad)) ? col_x - SW'(rad) : '0;
      top_c    = (row_y >= SW'(rad)) ? row_y - SW'(rad) : '0;
      right_c  = (col_hi > w_sat - SW'(1)) ? w_sat - SW'(1) : col_hi;
      bottom_c = (row_hi > h_sat - SW'(1)) ? h_sat - SW'(1) : row_hi;
   end

   assign in_frame   = (col_x < w_sat) && (row_y < h_sat);
   assign req_fire   = req_bus.valid && req_bus.ready;
   assign req_addr   = AW'(32'(req_bus.row) * 32'(MAX_WIDTH) + 32'(req_bus.col));
   assign sweep_addr = AW'(32'(y_ff) * 32'(MAX_WIDTH) + 32'(x_ff));
   assign out_free   = !rsp_valid_ff || rsp_bus.ready;

   // Configuration write port, always ready
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b1;
         radius_ff  <= bmf_pkg::RAD_W'(1);
         fwidth_ff  <= SW'(512);
         fheight_ff <= SW'(512);
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            bmf_pkg::CSR_ENABLED:      enabled_ff <= csr_bus.data[0];
            bmf_pkg::CSR_RADIUS:       radius_ff  <= csr_bus.data[bmf_pkg::RAD_W-1:0];
            bmf_pkg::CSR_FRAME_WIDTH:  fwidth_ff  <= csr_bus.data[SW-1:0];
            bmf_pkg::CSR_FRAME_HEIGHT: fheight_ff <= csr_bus.data[SW-1:0];
            default: ;
         endcase
      end
   end

   // Next state and memory control
   always_comb begin
      state_in = state_ff;
      mem_we   = 1'b0;
      mem_re   = 1'b0;
      rd_addr  = sweep_addr;
      wr_addr  = req_addr;
      req_bus.ready = (state_ff == bmf_pkg::S_IDLE);
      case (state_ff)
         bmf_pkg::S_IDLE: begin
            if (req_fire && in_frame) begin
               if (req_bus.action == bmf_pkg::ACT_LOAD) begin
                  mem_we = 1'b1;
               end else begin
                  state_in = bmf_pkg::S_CENTRE;
               end
            end
         end
         bmf_pkg::S_CENTRE: begin
            mem_re   = 1'b1;
            rd_addr  = cen_addr_ff;
            state_in = pass_ff ? bmf_pkg::S_DRAIN : bmf_pkg::S_SWEEP;
         end
         bmf_pkg::S_SWEEP: begin
            mem_re = 1'b1;
            if (x_ff == right_ff && y_ff == bottom_ff) begin
               state_in = bmf_pkg::S_DRAIN;
            end
         end
         bmf_pkg::S_DRAIN: begin
            state_in = pass_ff ? bmf_pkg::S_FINISH : bmf_pkg::S_DIV;
         end
         bmf_pkg::S_DIV: begin
            if (step_ff == 3'd7) begin
               state_in = bmf_pkg::S_FINISH;
            end
         end
         bmf_pkg::S_FINISH: begin
            if (out_free) begin
               state_in = bmf_pkg::S_IDLE;
            end
         end
         default: state_in = bmf_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bmf_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Frame store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= {req_bus.alpha_in, req_bus.red_in, req_bus.green_in, req_bus.blue_in};
      end
      if (mem_re) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   // Restoring division step: one quotient bit per channel
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         qbit[ch]     = (XW'(sum_ff[ch]) >= XW'(div_ff));
         rem_next[ch] = qbit[ch] ? SUMW'(XW'(sum_ff[ch]) - XW'(div_ff)) : sum_ff[ch];
      end
   end

   // Read data flags and sweep datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_en_ff <= 1'b0;
         cen_en_ff <= 1'b0;
      end else begin
         acc_en_ff <= (state_ff == bmf_pkg::S_SWEEP);
         cen_en_ff <= (state_ff == bmf_pkg::S_CENTRE);
      end
   end

   always_ff @(posedge clock) begin
      // Capture centre pixel in the cycle after its read
      if (cen_en_ff) begin
         centre_ff <= mem_q_ff;
      end
      case (state_ff)
         bmf_pkg::S_IDLE: begin
            cen_addr_ff <= req_addr;
            pass_ff     <= !enabled_ff;
            x_ff        <= left_c;
            y_ff        <= top_c;
            left_ff     <= left_c;
            right_ff    <= right_c;
            bottom_ff   <= bottom_c;
            cnt_ff      <= '0;
            for (int ch = 0; ch < 3; ch++) begin
               sum_ff[ch] <= '0;
            end
         end
         bmf_pkg::S_SWEEP: begin
            cnt_ff <= cnt_ff + CNTW'(1);
            if (x_ff == right_ff) begin
               x_ff <= left_ff;
               y_ff <= y_ff + SW'(1);
            end else begin
               x_ff <= x_ff + SW'(1);
            end
            if (acc_en_ff) begin
               for (int ch = 0; ch < 3; ch++) begin
                  sum_ff[ch] <= sum_ff[ch] + SUMW'(mem_q_ff[ch*CHW +: CHW]);
               end
            end
         end
         bmf_pkg::S_DRAIN: begin
            // Add the last window pixel, align divisor to the top quotient bit
            if (acc_en_ff) begin
               for (int ch = 0; ch < 3; ch++) begin
                  sum_ff[ch] <= sum_ff[ch] + SUMW'(mem_q_ff[ch*CHW +: CHW]);
               end
            end
            div_ff  <= {cnt_ff, {(CHW-1){1'b0}}};
            step_ff <= '0;
         end
         bmf_pkg::S_DIV: begin
            for (int ch = 0; ch < 3; ch++) begin
               sum_ff[ch] <= rem_next[ch];
               q_ff[ch]   <= {q_ff[ch][CHW-2:0], qbit[ch]};
            end
            div_ff  <= div_ff >> 1;
            step_ff <= step_ff + 3'd1;
         end
         default: ;
      endcase
   end

   // Output register: load when the last result is gone or leaving now
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == bmf_pkg::S_FINISH && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == bmf_pkg::S_FINISH && out_free) begin
         rsp_a_ff       <= centre_ff[3*CHW +: CHW];
         rsp_applied_ff <= !pass_ff;
         if (pass_ff) begin
            rsp_b_ff <= centre_ff[0 +: CHW];
            rsp_g_ff <= centre_ff[CHW +: CHW];
            rsp_r_ff <= centre_ff[2*CHW +: CHW];
         end else begin
            rsp_b_ff <= q_ff[0];
            rsp_g_ff <= q_ff[1];
            rsp_r_ff <= q_ff[2];
         end
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.blue_out  = rsp_b_ff;
   assign rsp_bus.green_out = rsp_g_ff;
   assign rsp_bus.red_out   = rsp_r_ff;
   assign rsp_bus.alpha_out = rsp_a_ff;
   assign rsp_bus.applied   = rsp_applied_ff;

   // Sweep position stays inside the clipped window
   a_sweep_in_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == bmf_pkg::S_SWEEP |->
         x_ff >= left_ff && x_ff <= right_ff && y_ff <= bottom_ff)
      else $error("sweep position left the window");

   // A filtered result leaves a remainder below the pixel count
   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      state_ff == bmf_pkg::S_FINISH && !pass_ff |->
         XW'(sum_ff[0]) < XW'(cnt_ff) && XW'(sum_ff[1]) < XW'(cnt_ff) &&
         XW'(sum_ff[2]) < XW'(cnt_ff))
      else $error("division remainder not below pixel count");

   // Division never starts on an empty window
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == bmf_pkg::S_DIV |-> cnt_ff != '0)
      else $error("division with zero pixel count");

   // A full output register is never overwritten before it is taken
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready |=> rsp_valid_ff && $stable(rsp_b_ff) &&
         $stable(rsp_applied_ff))
      else $error("pending result overwritten");

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the box mean image filter
// Loads pixels, queries filtered pixels under many register settings and
// compares every result field against a behavioral copy of the frame store
// and of the window averaging, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Watchdog: even at 83% idling, every item as a full radius-15 query
   // stays far below this.
   localparam int CYCLE_LIMIT   = 3_000_000;
   // Quiet cycles after the last result, to let a trailing load or dropped
   // item retire.
   localparam int SETTLE_CYCLES = 32;
   localparam int PHASE_ITEMS   = 62;
   localparam int STORE_DEPTH   = bmf_pkg::DEF_MAX_WIDTH * bmf_pkg::DEF_MAX_HEIGHT;

   typedef struct {
      logic                          action;
      logic [bmf_pkg::COORD_W-1:0]   col;
      logic [bmf_pkg::COORD_W-1:0]   row;
      logic [bmf_pkg::CHAN_W-1:0]    blue;
      logic [bmf_pkg::CHAN_W-1:0]    green;
      logic [bmf_pkg::CHAN_W-1:0]    red;
      logic [bmf_pkg::CHAN_W-1:0]    alpha;
   } pixel_req_type;

   typedef struct {
      logic [bmf_pkg::CHAN_W-1:0]    blue;
      logic [bmf_pkg::CHAN_W-1:0]    green;
      logic [bmf_pkg::CHAN_W-1:0]    red;
      logic [bmf_pkg::CHAN_W-1:0]    alpha;
      logic                          applied;
   } filtered_px_type;

   logic clock;
   logic reset;

   bmf_req_if req ();
   bmf_rsp_if rsp ();
   bmf_csr_if csr ();

   box_mean_image_filter uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req),
      .rsp_bus (rsp),
      .csr_bus (csr)
   );

   // Shadow of the block: frame store, which entries hold a loaded pixel,
   // and the register values as last written.
   logic [bmf_pkg::PIX_W-1:0]  frame_copy   [STORE_DEPTH];
   bit                         pixel_loaded [STORE_DEPTH];
   logic                       cfg_enabled;
   logic [bmf_pkg::RAD_W-1:0]  cfg_radius;
   logic [bmf_pkg::SIZE_W-1:0] cfg_width;
   logic [bmf_pkg::SIZE_W-1:0] cfg_height;

   filtered_px_type expected_pixels [$];

   int src_idle_pct;
   int snk_idle_pct;
   int errors;
   int items_counted;
   int cycle_count;

   // ------------------------------------------------------------------------
   // Shadow helpers
   // ------------------------------------------------------------------------
   function automatic int pix_addr(input int c, input int r);
      return r * bmf_pkg::DEF_MAX_WIDTH + c;
   endfunction

   // Zero acts as one, anything past the store saturates.
   function automatic int clamp_size(input int v, input int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // Pixels a query at (c, r) reads: the clipped window, or the centre alone
   // when the filter is off.
   function automatic void read_bounds(input int c, input int r, output int left,
                                       output int right, output int top, output int bottom);
      int rad;
      int w;
      int h;
      w = clamp_size(cfg_width, bmf_pkg::DEF_MAX_WIDTH);
      h = clamp_size(cfg_height, bmf_pkg::DEF_MAX_HEIGHT);
      rad = (cfg_radius > bmf_pkg::DEF_MAX_RADIUS) ? bmf_pkg::DEF_MAX_RADIUS : cfg_radius;
      if (!cfg_enabled) rad = 0;
      left   = (c >= rad) ? c - rad : 0;
      top    = (r >= rad) ? r - rad : 0;
      right  = (c + rad > w - 1) ? w - 1 : c + rad;
      bottom = (r + rad > h - 1) ? h - 1 : r + rad;
   endfunction

   function automatic bit window_loaded(input int c, input int r);
      int left, right, top, bottom;
      read_bounds(c, r, left, right, top, bottom);
      for (int y = top; y <= bottom; y++)
         for (int x = left; x <= right; x++)
            if (!pixel_loaded[pix_addr(x, y)]) return 1'b0;
      return 1'b1;
   endfunction

   // Pixel packed as {alpha, red, green, blue}.
   function automatic pixel_req_type pixel_item(input logic act, input int c, input int r,
                                                input logic [bmf_pkg::PIX_W-1:0] bgra);
      pixel_req_type it;
      it.action = act;
      it.col    = bmf_pkg::COORD_W'(c);
      it.row    = bmf_pkg::COORD_W'(r);
      it.blue   = bgra[7:0];
      it.green  = bgra[15:8];
      it.red    = bgra[23:16];
      it.alpha  = bgra[31:24];
      return it;
   endfunction

   // Apply one accepted item to the shadow: store a load, or queue the
   // filtered pixel a query must return. Dropped items leave no trace.
   function automatic void filter_item(input pixel_req_type it);
      int w, h, left, right, top, bottom;
      int sb, sg, sr, count;
      logic [bmf_pkg::PIX_W-1:0] centre;
      logic [bmf_pkg::PIX_W-1:0] p;
      filtered_px_type px;
      w = clamp_size(cfg_width, bmf_pkg::DEF_MAX_WIDTH);
      h = clamp_size(cfg_height, bmf_pkg::DEF_MAX_HEIGHT);
      if (it.col >= w || it.row >= h) return;
      items_counted++;
      if (it.action == bmf_pkg::ACT_LOAD) begin
         frame_copy[pix_addr(it.col, it.row)]   = {it.alpha, it.red, it.green, it.blue};
         pixel_loaded[pix_addr(it.col, it.row)] = 1'b1;
         return;
      end
      centre = frame_copy[pix_addr(it.col, it.row)];
      if (!cfg_enabled) begin
         px = '{centre[7:0], centre[15:8], centre[23:16], centre[31:24], 1'b0};
      end else begin
         sb = 0;
         sg = 0;
         sr = 0;
         read_bounds(it.col, it.row, left, right, top, bottom);
         for (int y = top; y <= bottom; y++) begin
            for (int x = left; x <= right; x++) begin
               p = frame_copy[pix_addr(x, y)];
               sb += p[7:0];
               sg += p[15:8];
               sr += p[23:16];
            end
         end
         count = (right - left + 1) * (bottom - top + 1);
         px = '{bmf_pkg::CHAN_W'(sb / count), bmf_pkg::CHAN_W'(sg / count),
                bmf_pkg::CHAN_W'(sr / count), centre[31:24], 1'b1};
      end
      expected_pixels.push_back(px);
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Channel tasks
   // ------------------------------------------------------------------------

   // Offer one item, idling at random first, and hold it until taken.
   // Valid stays high after the handshake so a back-to-back item needs no
   // second assignment in the same step.
   task automatic send_item(input pixel_req_type it);
      while ($urandom_range(99) < src_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid    <= 1'b1;
      req.action   <= it.action;
      req.col      <= it.col;
      req.row      <= it.row;
      req.blue_in  <= it.blue;
      req.green_in <= it.green;
      req.red_in   <= it.red;
      req.alpha_in <= it.alpha;
      @(posedge clock);
      while (req.ready !== 1'b1) @(posedge clock);
      filter_item(it);
   endtask

   // Drop valid, wait for every pending query to answer, then let any
   // trailing load retire.
   task automatic settle_block();
      req.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all four registers back to back while the block is idle.
   task automatic configure(input logic en, input logic [bmf_pkg::RAD_W-1:0] rad,
                            input logic [bmf_pkg::SIZE_W-1:0] w,
                            input logic [bmf_pkg::SIZE_W-1:0] h);
      logic [bmf_pkg::CSR_IDX_W-1:0]  idx   [4];
      logic [bmf_pkg::CSR_DATA_W-1:0] value [4];
      settle_block();
      idx   = '{bmf_pkg::CSR_ENABLED, bmf_pkg::CSR_RADIUS, bmf_pkg::CSR_FRAME_WIDTH,
                bmf_pkg::CSR_FRAME_HEIGHT};
      value = '{bmf_pkg::CSR_DATA_W'(en), bmf_pkg::CSR_DATA_W'(rad),
                bmf_pkg::CSR_DATA_W'(w), bmf_pkg::CSR_DATA_W'(h)};
      for (int k = 0; k < 4; k++) begin
         csr.valid <= 1'b1;
         csr.index <= idx[k];
         csr.data  <= value[k];
         @(posedge clock);
         while (csr.ready !== 1'b1) @(posedge clock);
      end
      csr.valid   <= 1'b0;
      cfg_enabled = en;
      cfg_radius  = rad;
      cfg_width   = w;
      cfg_height  = h;
   endtask

   // Load every not yet loaded pixel that a query at (c, r) would read.
   task automatic load_window(input int c, input int r);
      int left, right, top, bottom;
      read_bounds(c, r, left, right, top, bottom);
      for (int y = top; y <= bottom; y++)
         for (int x = left; x <= right; x++)
            if (!pixel_loaded[pix_addr(x, y)])
               send_item(pixel_item(bmf_pkg::ACT_LOAD, x, y, $urandom));
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Reset settings: radius 1 over the full frame. Hit both clipped corners
   // with all-zero and all-one pixels, and an odd value to force truncation.
   task automatic test_corners();
      send_item(pixel_item(bmf_pkg::ACT_LOAD, 0, 0, 32'h0000_0000));
      send_item(pixel_item(bmf_pkg::ACT_LOAD, 1, 0, 32'hFFFF_FFFF));
      send_item(pixel_item(bmf_pkg::ACT_LOAD, 0, 1, 32'hFFFF_FFFF));
      send_item(pixel_item(bmf_pkg::ACT_LOAD, 1, 1, 32'h8001_7F02));
      send_item(pixel_item(bmf_pkg::ACT_QUERY, 0, 0, 32'hFFFF_FFFF));
      send_item(pixel_item(bmf_pkg::ACT_LOAD, 511, 511, 32'hFFFF_FFFF));
      send_item(pixel_item(bmf_pkg::ACT_LOAD, 510, 511, 32'hFFFF_FFFF));
      send_item(pixel_item(bmf_pkg::ACT_LOAD, 511, 510, 32'h00FF_FFFF));
      send_item(pixel_item(bmf_pkg::ACT_LOAD, 510, 510, 32'h5501_0000));
      send_item(pixel_item(bmf_pkg::ACT_QUERY, 511, 511, 32'h0000_0000));
   endtask

   // Filter off: stored pixels come back as they are, applied low.
   task automatic test_passthrough();
      configure(1'b0, 4'd1, 10'd512, 10'd512);
      send_item(pixel_item(bmf_pkg::ACT_QUERY, 0, 0, $urandom));
      send_item(pixel_item(bmf_pkg::ACT_QUERY, 511, 511, $urandom));
      send_item(pixel_item(bmf_pkg::ACT_QUERY, 1, 0, $urandom));
   endtask

   // Frame sizes of zero and beyond the store, items outside the frame,
   // radius zero and the largest radius.
   task automatic test_frame_limits();
      // width zero acts as one column of three rows
      configure(1'b1, 4'd1, 10'd0, 10'd3);
      send_item(pixel_item(bmf_pkg::ACT_LOAD, 0, 2, $urandom));
      // outside the frame: must not overwrite the stored pixel
      send_item(pixel_item(bmf_pkg::ACT_LOAD, 1, 0, 32'h1234_5678));
      send_item(pixel_item(bmf_pkg::ACT_QUERY, 1, 0, $urandom));
      send_item(pixel_item(bmf_pkg::ACT_QUERY, 0, 1, $urandom));
      send_item(pixel_item(bmf_pkg::ACT_QUERY, 0, 2, $urandom));
      send_item(pixel_item(bmf_pkg::ACT_LOAD, 0, 3, $urandom));
      send_item(pixel_item(bmf_pkg::ACT_QUERY, 0, 3, $urandom));
      // width saturates to the store, height zero acts as one row
      configure(1'b1, 4'd0, 10'd1023, 10'd0);
      send_item(pixel_item(bmf_pkg::ACT_QUERY, 1, 0, $urandom));
      send_item(pixel_item(bmf_pkg::ACT_LOAD, 511, 0, $urandom));
      send_item(pixel_item(bmf_pkg::ACT_QUERY, 511, 0, $urandom));
      // largest radius on a single pixel frame
      configure(1'b1, 4'd15, 10'd1, 10'd1);
      send_item(pixel_item(bmf_pkg::ACT_QUERY, 0, 0, $urandom));
   endtask

   // One random phase: mostly filled windows followed by a query, some
   // overwrites, and noise that lands anywhere in the address space.
   task automatic run_phase(input logic en, input logic [bmf_pkg::RAD_W-1:0] rad,
                            input logic [bmf_pkg::SIZE_W-1:0] w,
                            input logic [bmf_pkg::SIZE_W-1:0] h);
      int stop_at, pause_at, c, r, pick;
      bit paused;
      pixel_req_type it;
      configure(en, rad, w, h);
      stop_at  = items_counted + PHASE_ITEMS;
      pause_at = items_counted + PHASE_ITEMS / 2;
      paused   = 1'b0;
      while (items_counted < stop_at) begin
         if (!paused && items_counted >= pause_at) begin
            // hold off new items until every query in flight has answered
            settle_block();
            paused = 1'b1;
         end
         pick = $urandom_range(99);
         c = $urandom_range(clamp_size(cfg_width, bmf_pkg::DEF_MAX_WIDTH) - 1);
         r = $urandom_range(clamp_size(cfg_height, bmf_pkg::DEF_MAX_HEIGHT) - 1);
         if (pick < 60) begin
            load_window(c, r);
            send_item(pixel_item(bmf_pkg::ACT_QUERY, c, r, $urandom));
         end else if (pick < 85) begin
            send_item(pixel_item(bmf_pkg::ACT_LOAD, c, r, $urandom));
         end else begin
            c  = $urandom_range(bmf_pkg::DEF_MAX_WIDTH - 1);
            r  = $urandom_range(bmf_pkg::DEF_MAX_HEIGHT - 1);
            it = pixel_item(1'($urandom_range(1)), c, r, $urandom);
            // never read a pixel that was never loaded: turn such a query into a load
            if (it.action == bmf_pkg::ACT_QUERY && !window_loaded(c, r)) begin
               it.action = bmf_pkg::ACT_LOAD;
            end
            send_item(it);
         end
      end
   endtask

   task automatic test_random();
      src_idle_pct = 16;
      snk_idle_pct = 83;
      run_phase(1'b1, 4'd1, 10'd8, 10'd6);
      run_phase(1'b1, 4'd15, 10'd6, 10'd5);
      run_phase(1'b1, 4'd0, 10'd512, 10'd512);
      src_idle_pct = 83;
      snk_idle_pct = 16;
      run_phase(1'b0, 4'd7, 10'd5, 10'd5);
      run_phase(1'b1, 4'd3, 10'd0, 10'd40);
      run_phase(1'b1, 4'd2, 10'd700, 10'd1);
      src_idle_pct = 0;
      snk_idle_pct = 0;
      run_phase(1'b1, 4'd15, 10'd1, 10'd1);
      run_phase(1'b1, 4'd1, 10'd512, 10'd512);
      run_phase(1'b1, 4'd2, 10'd16, 10'd12);
   endtask

   // ------------------------------------------------------------------------
   // Processes
   // ------------------------------------------------------------------------

   // Free-running clock, 4 ns period.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Result side: stall at random at the current rate, low during reset.
   initial begin : result_ready
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp.ready <= !reset && ($urandom_range(99) >= snk_idle_pct);
      end
   end

   // Compare every accepted result with the oldest pending expectation.
   initial begin : result_check
      filtered_px_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
            if (expected_pixels.size() == 0) begin
               $error("result with no query pending");
               errors++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("blue_out", want.blue, rsp.blue_out);
               check_field("green_out", want.green, rsp.green_out);
               check_field("red_out", want.red, rsp.red_out);
               check_field("alpha_out", want.alpha, rsp.alpha_out);
               check_field("applied", want.applied, rsp.applied);
            end
         end
      end
   end

   // Stop a hung run.
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[box_mean_image_filter] ERROR");
      $finish;
   end

   initial begin : main_sequence
      // drive every input to a known value and hold reset
      reset        <= 1'b1;
      req.valid    <= 1'b0;
      req.action   <= bmf_pkg::ACT_LOAD;
      req.col      <= '0;
      req.row      <= '0;
      req.blue_in  <= '0;
      req.green_in <= '0;
      req.red_in   <= '0;
      req.alpha_in <= '0;
      csr.valid    <= 1'b0;
      csr.index    <= bmf_pkg::CSR_ENABLED;
      csr.data     <= '0;
      errors        = 0;
      items_counted = 0;
      src_idle_pct  = 16;
      snk_idle_pct  = 83;
      // register values after reset
      cfg_enabled = 1'b1;
      cfg_radius  = 4'd1;
      cfg_width   = 10'd512;
      cfg_height  = 10'd512;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_corners();
      test_passthrough();
      test_frame_limits();
      test_random();

      // drain: nothing pending, then quiet cycles for any trailing load
      settle_block();
      if (errors == 0) begin
         $display("[box_mean_image_filter] OK");
      end else begin
         $display("[box_mean_image_filter] ERROR");
      end
      $finish;
   end

endmodule
